>>> hdl/thr_pkg.sv
// shared constants, codes and pipeline sideband type for the temporal history resolve
package thr_pkg;

    localparam int CHANNEL_BITS_DEF = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int SQRT_IN_W  = 40;
    localparam int SQRT_OUT_W = SQRT_IN_W / 2;
    localparam int DIV_NUM_W  = 36;
    localparam int DIV_DEN_W  = 20;

    localparam logic [16:0] ONE_Q16 = 17'h10000;

    localparam logic [CFG_IDX_W-1:0] REG_HISTORY_WEIGHT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_REL      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_ABS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MOTION_LIMIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_SIZE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RENDER_SIZE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_JITTER_NOW     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_JITTER_BEFORE  = 3'd7;

    localparam logic [16:0] RST_HISTORY_WEIGHT = 17'd58982;
    localparam logic [15:0] RST_DEPTH_REL      = 16'd655;
    localparam logic [31:0] RST_DEPTH_ABS      = 32'd7;
    localparam logic [15:0] RST_MOTION_LIMIT   = 16'd2048;

    localparam logic [2:0] RC_ACCEPT    = 3'd0;
    localparam logic [2:0] RC_INVALID   = 3'd1;
    localparam logic [2:0] RC_NO_HIST   = 3'd2;
    localparam logic [2:0] RC_MOTION    = 3'd3;
    localparam logic [2:0] RC_OUTSIDE   = 3'd4;
    localparam logic [2:0] RC_DISOCCL   = 3'd5;

    typedef struct packed {
        logic [63:0]       cur;
        logic [47:0]       hist;
        logic [2:0]        code;
        logic              depth_rej;
        logic [1:0][15:0]  size;
        logic [1:0]        jn_neg;
        logic [1:0]        mv_neg;
        logic [1:0]        jb_neg;
        logic              lim_zero;
        logic [16:0]       hw;
        logic [1:0][29:0]  cnum;
        logic [1:0][16:0]  cden;
        logic [1:0][23:0]  jnum;
        logic [1:0][27:0]  mnum;
        logic [1:0][23:0]  bnum;
        logic [1:0][15:0]  rsz;
        logic [19:0]       lim16;
    } sb_t;

endpackage

>>> hdl/thr_if.sv
// pixel and result channel interfaces
interface thr_pixel_if;
    logic               valid;
    logic               ready;
    logic [12:0]        pixel_x;
    logic [12:0]        pixel_y;
    logic [63:0]        current_rgba;
    logic               has_history;
    logic signed [15:0] motion_dx;
    logic signed [15:0] motion_dy;
    logic               depth_present;
    logic [31:0]        depth_now;
    logic [31:0]        depth_before;
    logic [47:0]        history_rgb;
    logic [47:0]        box_low;
    logic [47:0]        box_high;

    modport source (output valid, pixel_x, pixel_y, current_rgba, has_history, motion_dx,
                    motion_dy, depth_present, depth_now, depth_before, history_rgb,
                    box_low, box_high, input ready);
    modport sink (input valid, pixel_x, pixel_y, current_rgba, has_history, motion_dx,
                  motion_dy, depth_present, depth_now, depth_before, history_rgb,
                  box_low, box_high, output ready);
endinterface

interface thr_result_if;
    logic        valid;
    logic        ready;
    logic [63:0] resolved_rgba;
    logic [2:0]  reject_code;
    logic [16:0] applied_weight;
    logic [35:0] render_uv_now;
    logic [35:0] render_uv_before;
    logic [35:0] history_uv;

    modport source (output valid, resolved_rgba, reject_code, applied_weight, render_uv_now,
                    render_uv_before, history_uv, input ready);
    modport sink (input valid, resolved_rgba, reject_code, applied_weight, render_uv_now,
                  render_uv_before, history_uv, output ready);
endinterface

>>> hdl/thr_delay.sv
// valid and data delay line with common stall
module thr_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic         in_valid,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    output logic [W-1:0] out_data
);
    logic         v_reg [DEPTH];
    logic [W-1:0] d_reg [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DEPTH; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int k = 1; k < DEPTH; k++)
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg[0] <= in_data;
            for (int k = 1; k < DEPTH; k++)
            begin
                d_reg[k] <= d_reg[k-1];
            end
        end
    end

    assign out_valid = v_reg[DEPTH-1];
    assign out_data  = d_reg[DEPTH-1];
endmodule

>>> hdl/thr_sqrt.sv
// pipelined integer square root, one root bit per stage
module thr_sqrt #(
    parameter int IN_W = 40
) (
    input  logic              clk,
    input  logic              en,
    input  logic [IN_W-1:0]   din,
    output logic [IN_W/2-1:0] root
);
    localparam int HW = IN_W / 2;
    localparam int RW = HW + 2;

    logic [RW-1:0]   rem_reg  [HW];
    logic [HW-1:0]   root_reg [HW];
    logic [IN_W-1:0] val_reg  [HW];

    for (genvar k = 0; k < HW; k++)
    begin : g_stage
        logic [RW-1:0]   rem_in;
        logic [HW-1:0]   root_in;
        logic [IN_W-1:0] val_in;
        logic [RW-1:0]   cand;
        logic [RW-1:0]   test;
        logic            ge;

        if (k == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign val_in  = din;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign val_in  = val_reg[k-1];
        end

        assign cand = {rem_in[RW-3:0], val_in[IN_W-1-2*k -: 2]};
        assign test = {root_in, 2'b01};
        assign ge   = cand >= test;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? cand - test : cand;
                root_reg[k] <= {root_in[HW-2:0], ge};
                val_reg[k]  <= val_in;
            end
        end
    end

    assign root = root_reg[HW-1];
endmodule

>>> hdl/thr_div.sv
// pipelined unsigned restoring divider, one quotient bit per stage
module thr_div #(
    parameter int NUM_W = 36,
    parameter int DEN_W = 20
) (
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quo,
    output logic [DEN_W-1:0] rem
);
    logic [DEN_W-1:0] rem_reg [NUM_W];
    logic [NUM_W-1:0] quo_reg [NUM_W];
    logic [NUM_W-1:0] num_reg [NUM_W];
    logic [DEN_W-1:0] den_reg [NUM_W];

    for (genvar k = 0; k < NUM_W; k++)
    begin : g_stage
        logic [DEN_W-1:0] rem_in;
        logic [NUM_W-1:0] quo_in;
        logic [NUM_W-1:0] num_in;
        logic [DEN_W-1:0] den_in;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             ge;

        if (k == 0)
        begin : g_first
            assign rem_in = '0;
            assign quo_in = '0;
            assign num_in = num;
            assign den_in = den;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign num_in = num_reg[k-1];
            assign den_in = den_reg[k-1];
        end

        assign trial = {rem_in, num_in[NUM_W-1-k]};
        assign ge    = trial >= {1'b0, den_in};
        assign diff  = trial - {1'b0, den_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                quo_reg[k] <= {quo_in[NUM_W-2:0], ge};
                num_reg[k] <= num_in;
                den_reg[k] <= den_in;
            end
        end
    end

    assign quo = quo_reg[NUM_W-1];
    assign rem = rem_reg[NUM_W-1];
endmodule

>>> hdl/temporal_history_resolve_top.sv
// temporal history resolve: reject tests, neighborhood clamp and blend, one pixel per clock
// throughput: one pixel per cycle; depth set by the 20-stage square root and 36-stage dividers
// a stalled result freezes the whole pipeline, so ready is low only while the output waits
// reset: pipeline valid bits cleared, configuration registers take their defaults
module temporal_history_resolve_top #(
    parameter int CHANNEL_BITS = thr_pkg::CHANNEL_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [thr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [thr_pkg::CFG_DATA_W-1:0] cfg_data,
    thr_pixel_if.sink                     pixel,
    thr_result_if.source                  result
);
    import thr_pkg::*;

    localparam logic [15:0] CH_MASK = 16'((32'd1 << CHANNEL_BITS) - 32'd1);

    function automatic logic [15:0] mag16(input logic signed [15:0] v);
        mag16 = v[15] ? 16'(-v) : v;
    endfunction

    function automatic logic signed [31:0] floor_fix(input logic [DIV_NUM_W-1:0] q,
                                                     input logic [DIV_DEN_W-1:0] r,
                                                     input logic neg);
        logic signed [31:0] qs;
        qs = $signed(q[31:0]);
        floor_fix = neg ? -(qs + ((r != '0) ? 32'sd1 : 32'sd0)) : qs;
    endfunction

    function automatic logic [17:0] sat18(input logic signed [31:0] v);
        if (v < -32'sd131072)
            sat18 = 18'h20000;
        else if (v > 32'sd131071)
            sat18 = 18'h1ffff;
        else
            sat18 = v[17:0];
    endfunction

    // configuration registers
    logic [16:0] hw_cfg_reg;
    logic [15:0] rel_cfg_reg;
    logic [31:0] abs_cfg_reg;
    logic [15:0] lim_cfg_reg;
    logic [31:0] osize_cfg_reg;
    logic [31:0] rsize_cfg_reg;
    logic [31:0] jn_cfg_reg;
    logic [31:0] jb_cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hw_cfg_reg    <= RST_HISTORY_WEIGHT;
            rel_cfg_reg   <= RST_DEPTH_REL;
            abs_cfg_reg   <= RST_DEPTH_ABS;
            lim_cfg_reg   <= RST_MOTION_LIMIT;
            osize_cfg_reg <= '0;
            rsize_cfg_reg <= '0;
            jn_cfg_reg    <= '0;
            jb_cfg_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HISTORY_WEIGHT: hw_cfg_reg    <= cfg_data[16:0];
                REG_DEPTH_REL:      rel_cfg_reg   <= cfg_data[15:0];
                REG_DEPTH_ABS:      abs_cfg_reg   <= cfg_data;
                REG_MOTION_LIMIT:   lim_cfg_reg   <= cfg_data[15:0];
                REG_OUTPUT_SIZE:    osize_cfg_reg <= cfg_data;
                REG_RENDER_SIZE:    rsize_cfg_reg <= cfg_data;
                REG_JITTER_NOW:     jn_cfg_reg    <= cfg_data;
                REG_JITTER_BEFORE:  jb_cfg_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline advance
    logic out_valid_reg;
    logic en;
    logic take;

    assign en          = !out_valid_reg || result.ready;
    assign pixel.ready = en;
    assign take        = pixel.valid && en;

    // stage 1: squares, depth product, color masking and box clamp
    logic               s1_valid_reg;
    logic [12:0]        s1_px_reg;
    logic [12:0]        s1_py_reg;
    logic signed [15:0] s1_dx_reg;
    logic signed [15:0] s1_dy_reg;
    logic [31:0]        s1_mxx_reg;
    logic [31:0]        s1_myy_reg;
    logic [31:0]        s1_lim2_reg;
    logic [47:0]        s1_reldn_reg;
    logic [31:0]        s1_ddiff_reg;
    logic               s1_dnz_reg;
    logic               s1_dbz_reg;
    logic               s1_hh_reg;
    logic               s1_dp_reg;
    logic [63:0]        s1_cur_reg;
    logic [47:0]        s1_hist_reg;

    logic [63:0] cur_m;
    logic [47:0] hist_cl;

    always_comb
    begin
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] h;
        logic [15:0] lw;
        logic [15:0] up;
        for (int i = 0; i < 4; i++)
        begin
            cur_m[16*i +: 16] = pixel.current_rgba[16*i +: 16] & CH_MASK;
        end
        for (int i = 0; i < 3; i++)
        begin
            a  = pixel.box_low[16*i +: 16] & CH_MASK;
            b  = pixel.box_high[16*i +: 16] & CH_MASK;
            h  = pixel.history_rgb[16*i +: 16] & CH_MASK;
            lw = (a < b) ? a : b;
            up = (a < b) ? b : a;
            if (h < lw)
                h = lw;
            if (h > up)
                h = up;
            hist_cl[16*i +: 16] = h;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en)
            s1_valid_reg <= pixel.valid;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_px_reg    <= pixel.pixel_x;
            s1_py_reg    <= pixel.pixel_y;
            s1_dx_reg    <= pixel.motion_dx;
            s1_dy_reg    <= pixel.motion_dy;
            s1_mxx_reg   <= $signed(32'(pixel.motion_dx)) * $signed(32'(pixel.motion_dx));
            s1_myy_reg   <= $signed(32'(pixel.motion_dy)) * $signed(32'(pixel.motion_dy));
            s1_lim2_reg  <= 32'(lim_cfg_reg) * 32'(lim_cfg_reg);
            s1_reldn_reg <= 48'(rel_cfg_reg) * 48'(pixel.depth_now);
            s1_ddiff_reg <= (pixel.depth_now > pixel.depth_before)
                            ? pixel.depth_now - pixel.depth_before
                            : pixel.depth_before - pixel.depth_now;
            s1_dnz_reg   <= pixel.depth_now == '0;
            s1_dbz_reg   <= pixel.depth_before == '0;
            s1_hh_reg    <= pixel.has_history;
            s1_dp_reg    <= pixel.depth_present;
            s1_cur_reg   <= cur_m;
            s1_hist_reg  <= hist_cl;
        end
    end

    // stage 2 logic: motion and depth tests, divider operands
    sb_t                  s2_sb;
    logic [SQRT_IN_W-1:0] s2_sq_in;

    always_comb
    begin
        logic [31:0]        s;
        logic [47:0]        abs_sh;
        logic [47:0]        thr;
        logic               inv;
        logic signed [15:0] jnv [2];
        logic signed [15:0] jbv [2];
        logic signed [15:0] mvv [2];
        logic [12:0]        pv  [2];
        s      = s1_mxx_reg + s1_myy_reg;
        abs_sh = {abs_cfg_reg, 16'h0000};
        thr    = (abs_sh > s1_reldn_reg) ? abs_sh : s1_reldn_reg;
        inv    = (osize_cfg_reg[15:0] == '0) || (osize_cfg_reg[31:16] == '0) ||
                 (rsize_cfg_reg[15:0] == '0) || (rsize_cfg_reg[31:16] == '0);
        jnv[0] = jn_cfg_reg[15:0];
        jnv[1] = jn_cfg_reg[31:16];
        jbv[0] = jb_cfg_reg[15:0];
        jbv[1] = jb_cfg_reg[31:16];
        mvv[0] = s1_dx_reg;
        mvv[1] = s1_dy_reg;
        pv[0]  = s1_px_reg;
        pv[1]  = s1_py_reg;

        s2_sb.cur  = s1_cur_reg;
        s2_sb.hist = s1_hist_reg;
        if (inv)
            s2_sb.code = RC_INVALID;
        else if (!s1_hh_reg)
            s2_sb.code = RC_NO_HIST;
        else if (s > s1_lim2_reg)
            s2_sb.code = RC_MOTION;
        else
            s2_sb.code = RC_ACCEPT;
        s2_sb.depth_rej = s1_dp_reg && (s1_dnz_reg || s1_dbz_reg ||
                                        ({s1_ddiff_reg, 16'h0000} > thr));
        s2_sb.size[0]   = osize_cfg_reg[15:0];
        s2_sb.size[1]   = osize_cfg_reg[31:16];
        s2_sb.lim_zero  = lim_cfg_reg == '0;
        s2_sb.hw        = (hw_cfg_reg > ONE_Q16) ? ONE_Q16 : hw_cfg_reg;
        s2_sb.lim16     = {lim_cfg_reg, 4'h0};
        for (int i = 0; i < 2; i++)
        begin
            s2_sb.jn_neg[i] = jnv[i][15];
            s2_sb.mv_neg[i] = mvv[i][15];
            s2_sb.jb_neg[i] = jbv[i][15];
            s2_sb.cnum[i]   = {pv[i], 1'b1, 16'h0000};
            s2_sb.cden[i]   = {s2_sb.size[i], 1'b0};
            s2_sb.jnum[i]   = {mag16(jnv[i]), 8'h00};
            s2_sb.mnum[i]   = {mag16(mvv[i]), 12'h000};
            s2_sb.bnum[i]   = {mag16(jbv[i]), 8'h00};
        end
        s2_sb.rsz[0] = rsize_cfg_reg[15:0];
        s2_sb.rsz[1] = rsize_cfg_reg[31:16];
        s2_sq_in     = {s, 8'h00};
    end

    // square root of motion length, sideband alongside
    logic                  a_valid;
    logic [$bits(sb_t)-1:0] a_data;
    sb_t                   a_sb;
    logic [SQRT_OUT_W-1:0] len;

    thr_delay #(.W($bits(sb_t)), .DEPTH(SQRT_OUT_W)) u_delay_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s1_valid_reg),
        .in_data   (s2_sb),
        .out_valid (a_valid),
        .out_data  (a_data)
    );

    thr_sqrt #(.IN_W(SQRT_IN_W)) u_sqrt (
        .clk  (clk),
        .en   (en),
        .din  (s2_sq_in),
        .root (len)
    );

    assign a_sb = sb_t'(a_data);

    // dividers
    logic [DIV_NUM_W-1:0] fq;
    logic [DIV_DEN_W-1:0] fr;
    logic [DIV_NUM_W-1:0] cq [2];
    logic [DIV_DEN_W-1:0] cr [2];
    logic [DIV_NUM_W-1:0] jq [2];
    logic [DIV_DEN_W-1:0] jr [2];
    logic [DIV_NUM_W-1:0] mq [2];
    logic [DIV_DEN_W-1:0] mr [2];
    logic [DIV_NUM_W-1:0] bq [2];
    logic [DIV_DEN_W-1:0] br [2];

    thr_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div_frac (
        .clk (clk),
        .en  (en),
        .num (DIV_NUM_W'({len, 16'h0000})),
        .den (DIV_DEN_W'(a_sb.lim16)),
        .quo (fq),
        .rem (fr)
    );

    for (genvar i = 0; i < 2; i++)
    begin : g_axis
        thr_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div_center (
            .clk (clk),
            .en  (en),
            .num (DIV_NUM_W'(a_sb.cnum[i])),
            .den (DIV_DEN_W'(a_sb.cden[i])),
            .quo (cq[i]),
            .rem (cr[i])
        );
        thr_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div_jnow (
            .clk (clk),
            .en  (en),
            .num (DIV_NUM_W'(a_sb.jnum[i])),
            .den (DIV_DEN_W'(a_sb.rsz[i])),
            .quo (jq[i]),
            .rem (jr[i])
        );
        thr_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div_motion (
            .clk (clk),
            .en  (en),
            .num (DIV_NUM_W'(a_sb.mnum[i])),
            .den (DIV_DEN_W'(a_sb.rsz[i])),
            .quo (mq[i]),
            .rem (mr[i])
        );
        thr_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div_jbefore (
            .clk (clk),
            .en  (en),
            .num (DIV_NUM_W'(a_sb.bnum[i])),
            .den (DIV_DEN_W'(a_sb.rsz[i])),
            .quo (bq[i]),
            .rem (br[i])
        );
    end

    logic                   b_valid;
    logic [$bits(sb_t)-1:0] b_data;
    sb_t                    b_sb;

    thr_delay #(.W($bits(sb_t)), .DEPTH(DIV_NUM_W)) u_delay_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (a_valid),
        .in_data   (a_data),
        .out_valid (b_valid),
        .out_data  (b_data)
    );

    assign b_sb = sb_t'(b_data);

    // post stages
    logic               p1_valid_reg;
    sb_t                p1_sb_reg;
    logic signed [31:0] p1_cx_reg [2];
    logic signed [31:0] p1_jn_reg [2];
    logic signed [31:0] p1_mv_reg [2];
    logic signed [31:0] p1_jb_reg [2];
    logic [16:0]        p1_conf_reg;

    logic               p2_valid_reg;
    sb_t                p2_sb_reg;
    logic signed [31:0] p2_uvn_reg [2];
    logic signed [31:0] p2_uvb_reg [2];
    logic signed [31:0] p2_uvh_reg [2];
    logic [16:0]        p2_w_reg;

    logic               p3_valid_reg;
    sb_t                p3_sb_reg;
    logic signed [31:0] p3_uvn_reg [2];
    logic signed [31:0] p3_uvb_reg [2];
    logic signed [31:0] p3_uvh_reg [2];
    logic [16:0]        p3_w_reg;
    logic signed [49:0] p3_prod_reg [2];
    logic [32:0]        p3_pc_reg [3];
    logic [32:0]        p3_ph_reg [3];

    logic [63:0] out_rgba_reg;
    logic [2:0]  out_code_reg;
    logic [16:0] out_w_reg;
    logic [35:0] out_uvn_reg;
    logic [35:0] out_uvb_reg;
    logic [35:0] out_uvh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_valid_reg  <= b_valid;
            p2_valid_reg  <= p1_valid_reg;
            p3_valid_reg  <= p2_valid_reg;
            out_valid_reg <= p3_valid_reg;
        end
    end

    logic [2:0]  p4_code;
    logic [63:0] p4_rgba;

    always_comb
    begin
        logic               outside;
        logic [17:0]        s2m1;
        logic signed [49:0] hi;
        logic [33:0]        sum;
        outside = 1'b0;
        for (int i = 0; i < 2; i++)
        begin
            s2m1 = {1'b0, p3_sb_reg.size[i], 1'b0} - 18'd1;
            hi   = $signed({16'h0000, s2m1, 16'h0000});
            if ((p3_prod_reg[i] < 50'sd65536) || (p3_prod_reg[i] > hi))
                outside = 1'b1;
        end
        if (p3_sb_reg.code != RC_ACCEPT)
            p4_code = p3_sb_reg.code;
        else if (outside)
            p4_code = RC_OUTSIDE;
        else if (p3_sb_reg.depth_rej)
            p4_code = RC_DISOCCL;
        else
            p4_code = RC_ACCEPT;

        p4_rgba[63:48] = p3_sb_reg.cur[63:48];
        for (int i = 0; i < 3; i++)
        begin
            sum = 34'(p3_pc_reg[i]) + 34'(p3_ph_reg[i]) + 34'd32768;
            p4_rgba[16*i +: 16] = sum[31:16] & CH_MASK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_sb_reg <= b_sb;
            for (int i = 0; i < 2; i++)
            begin
                p1_cx_reg[i] <= $signed({2'b00, cq[i][29:0]});
                p1_jn_reg[i] <= floor_fix(jq[i], jr[i], b_sb.jn_neg[i]);
                p1_mv_reg[i] <= floor_fix(mq[i], mr[i], b_sb.mv_neg[i]);
                p1_jb_reg[i] <= floor_fix(bq[i], br[i], b_sb.jb_neg[i]);
            end
            if (b_sb.lim_zero)
                p1_conf_reg <= ONE_Q16;
            else if (fq >= DIV_NUM_W'(ONE_Q16))
                p1_conf_reg <= '0;
            else
                p1_conf_reg <= ONE_Q16 - fq[16:0];

            p2_sb_reg <= p1_sb_reg;
            for (int i = 0; i < 2; i++)
            begin
                p2_uvn_reg[i] <= p1_cx_reg[i] + p1_jn_reg[i];
                p2_uvb_reg[i] <= p1_cx_reg[i] + p1_jn_reg[i] + p1_mv_reg[i];
                p2_uvh_reg[i] <= p1_cx_reg[i] + p1_jn_reg[i] + p1_mv_reg[i] - p1_jb_reg[i];
            end
            p2_w_reg <= 17'((34'(p1_sb_reg.hw) * 34'(p1_conf_reg)) >> 16);

            p3_sb_reg <= p2_sb_reg;
            p3_w_reg  <= p2_w_reg;
            for (int i = 0; i < 2; i++)
            begin
                p3_uvn_reg[i]  <= p2_uvn_reg[i];
                p3_uvb_reg[i]  <= p2_uvb_reg[i];
                p3_uvh_reg[i]  <= p2_uvh_reg[i];
                p3_prod_reg[i] <= 50'(p2_uvh_reg[i]) *
                                  50'($signed({1'b0, p2_sb_reg.size[i], 1'b0}));
            end
            for (int i = 0; i < 3; i++)
            begin
                p3_pc_reg[i] <= 33'(p2_sb_reg.cur[16*i +: 16]) * 33'(ONE_Q16 - p2_w_reg);
                p3_ph_reg[i] <= 33'(p2_sb_reg.hist[16*i +: 16]) * 33'(p2_w_reg);
            end

            out_code_reg <= p4_code;
            case (p4_code)
                RC_INVALID: out_rgba_reg <= '0;
                RC_ACCEPT:  out_rgba_reg <= p4_rgba;
                default:    out_rgba_reg <= p3_sb_reg.cur;
            endcase
            out_w_reg <= (p4_code == RC_ACCEPT) ? p3_w_reg : '0;
            if ((p4_code == RC_INVALID) || (p4_code == RC_NO_HIST) || (p4_code == RC_MOTION))
            begin
                out_uvn_reg <= '0;
                out_uvb_reg <= '0;
                out_uvh_reg <= '0;
            end
            else
            begin
                out_uvn_reg <= {sat18(p3_uvn_reg[1]), sat18(p3_uvn_reg[0])};
                out_uvb_reg <= {sat18(p3_uvb_reg[1]), sat18(p3_uvb_reg[0])};
                out_uvh_reg <= {sat18(p3_uvh_reg[1]), sat18(p3_uvh_reg[0])};
            end
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.resolved_rgba    = out_rgba_reg;
    assign result.reject_code      = out_code_reg;
    assign result.applied_weight   = out_w_reg;
    assign result.render_uv_now    = out_uvn_reg;
    assign result.render_uv_before = out_uvb_reg;
    assign result.history_uv       = out_uvh_reg;

`ifndef SYNTHESIS
    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.reject_code <= RC_DISOCCL))
        else $error("reject code out of range");

    a_weight_rejected: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && (result.reject_code != RC_ACCEPT) |-> (result.applied_weight == '0))
        else $error("nonzero weight on rejected pixel");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && (result.reject_code == RC_INVALID)
        |-> (result.resolved_rgba == '0) && (result.history_uv == '0))
        else $error("invalid current pixel not zeroed");

    a_weight_max: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.applied_weight <= ONE_Q16))
        else $error("applied weight above one");
`endif
endmodule

>>> test/testbench.sv
// self-checking testbench for the temporal history resolve block
`timescale 1ns / 1ps

module testbench;
    import thr_pkg::*;

    typedef struct {
        logic [12:0]        px;
        logic [12:0]        py;
        logic [63:0]        cur;
        logic               has_hist;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic               depth_on;
        logic [31:0]        dn;
        logic [31:0]        db;
        logic [47:0]        hist;
        logic [47:0]        lo;
        logic [47:0]        hi;
    } pixel_t;

    typedef struct {
        logic [63:0] rgba;
        logic [2:0]  code;
        logic [16:0] weight;
        logic [35:0] uv_now;
        logic [35:0] uv_before;
        logic [35:0] uv_hist;
    } resolved_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    thr_pixel_if pix();
    thr_result_if res();

    temporal_history_resolve_top uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .pixel(pix),
        .result(res)
    );

    logic [16:0] hw_reg;
    logic [15:0] rel_reg;
    logic [31:0] abs_reg;
    logic [15:0] lim_reg;
    logic [31:0] out_size_reg;
    logic [31:0] render_size_reg;
    logic [31:0] jit_now_reg;
    logic [31:0] jit_before_reg;

    pixel_t pixel_queue[$];
    resolved_t resolved_queue[$];
    pixel_t next_px;
    int n_queued;
    int n_taken;
    int n_results;
    int n_errors;
    int code_seen[8];
    int idle_mode;
    bit hold_off;
    int quiet_cycles;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic longint floor_div(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q--;
        return q;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [35:0] pack_uv(longint x, longint y);
        logic [17:0] xs;
        logic [17:0] ys;
        if (x < -131072) x = -131072;
        if (x > 131071) x = 131071;
        if (y < -131072) y = -131072;
        if (y > 131071) y = 131071;
        xs = x[17:0];
        ys = y[17:0];
        return {ys, xs};
    endfunction

    function automatic resolved_t resolve_pixel(pixel_t p);
        resolved_t e;
        longint pc[2], sz[2], rs[2], jn[2], jb[2], mv[2];
        longint uvn[2], uvb[2], uvh[2];
        longint unsigned s, lim, gap, thr, hw, conf, len, frac, w;
        longint unsigned c, h, a, b, lw, up, r;
        bit outside;
        e.rgba = p.cur;
        e.code = RC_ACCEPT;
        e.weight = '0;
        e.uv_now = '0;
        e.uv_before = '0;
        e.uv_hist = '0;
        lim = lim_reg;
        pc[0] = p.px;
        pc[1] = p.py;
        sz[0] = out_size_reg[15:0];
        sz[1] = out_size_reg[31:16];
        rs[0] = render_size_reg[15:0];
        rs[1] = render_size_reg[31:16];
        jn[0] = $signed(jit_now_reg[15:0]);
        jn[1] = $signed(jit_now_reg[31:16]);
        jb[0] = $signed(jit_before_reg[15:0]);
        jb[1] = $signed(jit_before_reg[31:16]);
        mv[0] = p.dx;
        mv[1] = p.dy;
        if (sz[0] == 0 || sz[1] == 0 || rs[0] == 0 || rs[1] == 0)
        begin
            e.rgba = '0;
            e.code = RC_INVALID;
            return e;
        end
        if (!p.has_hist)
        begin
            e.code = RC_NO_HIST;
            return e;
        end
        s = mv[0] * mv[0] + mv[1] * mv[1];
        if (s > lim * lim)
        begin
            e.code = RC_MOTION;
            return e;
        end
        outside = 0;
        for (int i = 0; i < 2; i++)
        begin
            uvn[i] = floor_div((2 * pc[i] + 1) * 65536, 2 * sz[i]) + floor_div(jn[i] * 256, rs[i]);
            uvb[i] = uvn[i] + floor_div(mv[i] * 4096, rs[i]);
            uvh[i] = uvb[i] - floor_div(jb[i] * 256, rs[i]);
            if (uvh[i] * 2 * sz[i] < 65536 || uvh[i] * 2 * sz[i] > 65536 * (2 * sz[i] - 1))
                outside = 1;
        end
        e.uv_now = pack_uv(uvn[0], uvn[1]);
        e.uv_before = pack_uv(uvb[0], uvb[1]);
        e.uv_hist = pack_uv(uvh[0], uvh[1]);
        gap = p.dn > p.db ? p.dn - p.db : p.db - p.dn;
        thr = longint'(abs_reg) << 16;
        if (longint'(rel_reg) * p.dn > thr)
            thr = longint'(rel_reg) * p.dn;
        if (outside)
            e.code = RC_OUTSIDE;
        else if (p.depth_on && (p.dn == 0 || p.db == 0 || (gap << 16) > thr))
            e.code = RC_DISOCCL;
        else
        begin
            hw = hw_reg > 65536 ? 65536 : hw_reg;
            conf = 65536;
            if (lim != 0)
            begin
                len = root_floor(s << 8);
                frac = (len << 16) / (lim * 16);
                conf = frac >= 65536 ? 0 : 65536 - frac;
            end
            w = (hw * conf) >> 16;
            e.weight = w[16:0];
            for (int i = 0; i < 3; i++)
            begin
                c = p.cur[16*i +: 16];
                h = p.hist[16*i +: 16];
                a = p.lo[16*i +: 16];
                b = p.hi[16*i +: 16];
                lw = a < b ? a : b;
                up = a < b ? b : a;
                if (h < lw) h = lw;
                if (h > up) h = up;
                r = (c * (65536 - w) + h * w + 32768) >> 16;
                e.rgba[16*i +: 16] = r[15:0];
            end
        end
        return e;
    endfunction

    function automatic pixel_t random_pixel();
        pixel_t p;
        int unsigned w;
        int unsigned hgt;
        w = out_size_reg[15:0];
        hgt = out_size_reg[31:16];
        p.px = ($urandom_range(0, 3) != 0 && w != 0)
            ? 13'($urandom_range(0, (w > 8192 ? 8192 : w) - 1)) : 13'($urandom);
        p.py = ($urandom_range(0, 3) != 0 && hgt != 0)
            ? 13'($urandom_range(0, (hgt > 8192 ? 8192 : hgt) - 1)) : 13'($urandom);
        p.cur = {$urandom, $urandom};
        p.has_hist = $urandom_range(0, 9) != 0;
        if ($urandom_range(0, 9) < 7)
        begin
            p.dx = 16'($signed($urandom_range(0, 64)) - 32);
            p.dy = 16'($signed($urandom_range(0, 64)) - 32);
        end
        else
        begin
            p.dx = 16'($urandom);
            p.dy = 16'($urandom);
        end
        p.depth_on = $urandom_range(0, 1) != 0;
        p.dn = $urandom_range(0, 9) == 0 ? 32'd0 : $urandom;
        case ($urandom_range(0, 3))
            0: p.db = $urandom;
            1: p.db = 32'd0;
            default: p.db = p.dn + $urandom_range(0, 1024) - 512;
        endcase
        p.hist = 48'({$urandom, $urandom});
        p.lo = 48'({$urandom, $urandom});
        p.hi = 48'({$urandom, $urandom});
        return p;
    endfunction

    function automatic pixel_t plain_pixel(logic [12:0] x, logic [12:0] y, logic signed [15:0] dx,
                                           logic signed [15:0] dy);
        pixel_t p;
        p.px = x;
        p.py = y;
        p.cur = 64'h8000_1234_0800_0400;
        p.has_hist = 1;
        p.dx = dx;
        p.dy = dy;
        p.depth_on = 1;
        p.dn = 32'h0001_0000;
        p.db = 32'h0001_0004;
        p.hist = 48'h1000_2000_3000;
        p.lo = 48'h0800_0800_0800;
        p.hi = 48'h2000_2800_2800;
        return p;
    endfunction

    task automatic queue_pixel(pixel_t p);
        pixel_queue.push_back(p);
        n_queued++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_HISTORY_WEIGHT: hw_reg = val[16:0];
            REG_DEPTH_REL: rel_reg = val[15:0];
            REG_DEPTH_ABS: abs_reg = val;
            REG_MOTION_LIMIT: lim_reg = val[15:0];
            REG_OUTPUT_SIZE: out_size_reg = val;
            REG_RENDER_SIZE: render_size_reg = val;
            REG_JITTER_NOW: jit_now_reg = val;
            REG_JITTER_BEFORE: jit_before_reg = val;
            default: ;
        endcase
    endtask

    task automatic write_all(logic [31:0] hw, logic [31:0] rel, logic [31:0] abs_lim,
                             logic [31:0] lim, logic [31:0] osz, logic [31:0] rsz,
                             logic [31:0] jn, logic [31:0] jb);
        write_reg(REG_HISTORY_WEIGHT, hw);
        write_reg(REG_DEPTH_REL, rel);
        write_reg(REG_DEPTH_ABS, abs_lim);
        write_reg(REG_MOTION_LIMIT, lim);
        write_reg(REG_OUTPUT_SIZE, osz);
        write_reg(REG_RENDER_SIZE, rsz);
        write_reg(REG_JITTER_NOW, jn);
        write_reg(REG_JITTER_BEFORE, jb);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        wait (n_taken == n_queued && resolved_queue.size() == 0);
        repeat (80) @(posedge clk);
    endtask

    task automatic program_phase(int k);
        case (k)
            0: write_all(65536, 655, 7, 2048, 32'h0040_0040, 32'h0040_0040, 0, 0);
            1: write_all(0, 0, 0, 0, 32'h0001_0001, 32'hFFFF_FFFF, 32'h8000_8000, 32'h7FFF_7FFF);
            2: write_all(131071, 65535, 32'hFFFF_FFFF, 65535, 32'hFFFF_FFFF, 32'h0001_0001,
                         32'h7FFF_7FFF, 32'h8000_8000);
            3: write_all(32768, 3000, 32'h0001_0000, 64, 32'h0438_0780, 32'h021C_03C0,
                         {$urandom_range(0, 511) - 256} & 32'hFFFF, $urandom_range(0, 255) << 16);
            default: write_all($urandom_range(0, 131071), $urandom_range(0, 65535), $urandom,
                               $urandom_range(1, 512),
                               ($urandom_range(1, 300) << 16) | $urandom_range(1, 300),
                               ($urandom_range(1, 300) << 16) | $urandom_range(1, 300),
                               (($urandom_range(0, 511) - 256) << 16) |
                                   (($urandom_range(0, 511) - 256) & 32'hFFFF),
                               (($urandom_range(0, 511) - 256) << 16) |
                                   (($urandom_range(0, 511) - 256) & 32'hFFFF));
        endcase
    endtask

    initial
    begin
        pixel_t p;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        pix.valid = 1'b0;
        pix.pixel_x = '0;
        pix.pixel_y = '0;
        pix.current_rgba = '0;
        pix.has_history = 1'b0;
        pix.motion_dx = '0;
        pix.motion_dy = '0;
        pix.depth_present = 1'b0;
        pix.depth_now = '0;
        pix.depth_before = '0;
        pix.history_rgb = '0;
        pix.box_low = '0;
        pix.box_high = '0;
        res.ready = 1'b0;
        hw_reg = RST_HISTORY_WEIGHT;
        rel_reg = RST_DEPTH_REL;
        abs_reg = RST_DEPTH_ABS;
        lim_reg = RST_MOTION_LIMIT;
        out_size_reg = '0;
        render_size_reg = '0;
        jit_now_reg = '0;
        jit_before_reg = '0;
        idle_mode = 0;
        hold_off = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        // zero sizes after reset
        queue_pixel(plain_pixel(5, 5, 0, 0));
        queue_pixel(random_pixel());
        drain();
        program_phase(0);
        p = plain_pixel(32, 32, 0, 0);
        p.has_hist = 0;
        queue_pixel(p);
        queue_pixel(plain_pixel(32, 32, 16'sh7FFF, 0));
        queue_pixel(plain_pixel(32, 32, -16'sh8000, -16'sh8000));
        queue_pixel(plain_pixel(0, 0, -16, 0));
        queue_pixel(plain_pixel(8191, 8191, 0, 0));
        queue_pixel(plain_pixel(32, 32, 2048, 0));
        p = plain_pixel(32, 32, 0, 0);
        p.dn = 0;
        queue_pixel(p);
        p = plain_pixel(32, 32, 0, 0);
        p.db = 0;
        queue_pixel(p);
        p = plain_pixel(32, 32, 0, 0);
        p.db = 32'h0008_0000;
        queue_pixel(p);
        p.depth_on = 0;
        queue_pixel(p);
        queue_pixel(plain_pixel(32, 32, 0, 0));
        queue_pixel(plain_pixel(30, 40, 5, -7));
        p = plain_pixel(32, 32, 0, 0);
        p.cur = '1;
        p.hist = '1;
        p.lo = '1;
        p.hi = '1;
        queue_pixel(p);
        p = plain_pixel(32, 32, 3, 3);
        p.lo = 48'hFFFF_FFFF_FFFF;
        p.hi = 48'h0;
        queue_pixel(p);
        p.hist = 48'h0;
        p.lo = 48'h1000_1000_1000;
        p.hi = 48'h0100_0100_0100;
        queue_pixel(p);
        drain();
        for (int k = 0; k < 6; k++)
        begin
            program_phase(k);
            idle_mode = k / 2;
            for (int i = 0; i < 230; i++)
            begin
                queue_pixel(random_pixel());
                if (k == 1 && i == 115)
                begin
                    wait (pixel_queue.size() == 0);
                    hold_off = 1;
                    wait (n_taken == n_queued && resolved_queue.size() == 0);
                    hold_off = 0;
                end
            end
            drain();
        end
        $display("%0d pixels checked over 7 register settings with stalls on both sides", n_results);
        $display("codes seen: accept %0d invalid %0d no-history %0d motion %0d outside %0d depth %0d",
                 code_seen[0], code_seen[1], code_seen[2], code_seen[3], code_seen[4],
                 code_seen[5]);
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            pix.valid <= 1'b0;
        else if (!pix.valid || pix.ready)
        begin
            if (pixel_queue.size() != 0 && !hold_off &&
                !(idle_mode == 0 && $urandom_range(0, 99) < 37) &&
                !(idle_mode == 1 && $urandom_range(0, 99) < 60))
            begin
                next_px = pixel_queue.pop_front();
                pix.valid <= 1'b1;
                pix.pixel_x <= next_px.px;
                pix.pixel_y <= next_px.py;
                pix.current_rgba <= next_px.cur;
                pix.has_history <= next_px.has_hist;
                pix.motion_dx <= next_px.dx;
                pix.motion_dy <= next_px.dy;
                pix.depth_present <= next_px.depth_on;
                pix.depth_now <= next_px.dn;
                pix.depth_before <= next_px.db;
                pix.history_rgb <= next_px.hist;
                pix.box_low <= next_px.lo;
                pix.box_high <= next_px.hi;
            end
            else
                pix.valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            res.ready <= 1'b0;
        else
            res.ready <= !(idle_mode == 0 && $urandom_range(0, 99) < 60) &&
                         !(idle_mode == 1 && $urandom_range(0, 99) < 37);
    end

    always @(posedge clk)
    begin
        pixel_t p;
        resolved_t e;
        if (rst_n)
        begin
            if (pix.valid && pix.ready)
            begin
                p.px = pix.pixel_x;
                p.py = pix.pixel_y;
                p.cur = pix.current_rgba;
                p.has_hist = pix.has_history;
                p.dx = pix.motion_dx;
                p.dy = pix.motion_dy;
                p.depth_on = pix.depth_present;
                p.dn = pix.depth_now;
                p.db = pix.depth_before;
                p.hist = pix.history_rgb;
                p.lo = pix.box_low;
                p.hi = pix.box_high;
                resolved_queue.push_back(resolve_pixel(p));
                n_taken++;
            end
            if (res.valid && res.ready)
            begin
                n_results++;
                if (resolved_queue.size() == 0)
                begin
                    $error("result transaction with no expectation pending");
                    n_errors++;
                end
                else
                begin
                    e = resolved_queue.pop_front();
                    code_seen[e.code]++;
                    if (res.resolved_rgba !== e.rgba)
                    begin
                        $error("resolved_rgba expected %h got %h", e.rgba, res.resolved_rgba);
                        n_errors++;
                    end
                    if (res.reject_code !== e.code)
                    begin
                        $error("reject_code expected %0d got %0d", e.code, res.reject_code);
                        n_errors++;
                    end
                    if (res.applied_weight !== e.weight)
                    begin
                        $error("applied_weight expected %h got %h", e.weight, res.applied_weight);
                        n_errors++;
                    end
                    if (res.render_uv_now !== e.uv_now)
                    begin
                        $error("render_uv_now expected %h got %h", e.uv_now, res.render_uv_now);
                        n_errors++;
                    end
                    if (res.render_uv_before !== e.uv_before)
                    begin
                        $error("render_uv_before expected %h got %h", e.uv_before,
                               res.render_uv_before);
                        n_errors++;
                    end
                    if (res.history_uv !== e.uv_hist)
                    begin
                        $error("history_uv expected %h got %h", e.uv_hist, res.history_uv);
                        n_errors++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (pix.valid && pix.ready) || (res.valid && res.ready) || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles >= 20000)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule

>>> temporal_history_resolve_top.f
hdl/thr_pkg.sv
hdl/thr_if.sv
hdl/thr_delay.sv
hdl/thr_sqrt.sv
hdl/thr_div.sv
hdl/temporal_history_resolve_top.sv
test/testbench.sv
